/* rtl/core/jvpi_pkg.sv */
// shared types and constants for the joint velocity pi controller
`timescale 1ns / 1ps

package jvpi_pkg;

    // joint index width sets the size of the per-joint stores
    localparam int JOINT_INDEX_W    = 6;
    localparam int JOINT_COUNT      = 1 << JOINT_INDEX_W;
    localparam int FREE_FLYER_COUNT = 6;

    // configuration port
    localparam int PADDR_W     = 4;
    localparam int REG_INDEX_W = 2;

    localparam logic [REG_INDEX_W-1:0] REG_INVERSE_PERIOD    = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_PROPORTIONAL_GAIN = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_INTEGRAL_GAIN     = 2'd2;

    localparam logic        [31:0] INVERSE_PERIOD_RESET    = 32'd65536000;
    localparam logic signed [23:0] PROPORTIONAL_GAIN_RESET = 24'sd65536;
    localparam logic signed [23:0] INTEGRAL_GAIN_RESET     = 24'sd0;

    // saturation limits
    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;
    localparam logic signed [47:0] INT48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] INT48_MIN = 48'sh8000_0000_0000;

    // one joint sample
    typedef struct packed {
        logic        [JOINT_INDEX_W-1:0] joint_index;
        logic signed [31:0]              measured_position;
        logic signed [31:0]              reference_velocity;
    } sample_t;

    // one controller result
    typedef struct packed {
        logic        [JOINT_INDEX_W-1:0] joint_tag;
        logic signed [31:0]              estimated_velocity;
        logic signed [31:0]              drive_command;
        logic                            saturated_flag;
    } result_t;

endpackage

/* rtl/core/joint_velocity_pi_controller.sv */
// joint velocity pi controller: finite-difference velocity and per-joint pi loop
// throughput: one word per cycle while result_stall is low; per-joint position
// and integral stores are forwarded around their read-modify-write stages so
// back-to-back samples of one joint are fine
// reset: pipeline emptied, seen bits cleared, registers back to their reset values;
// position and integral memories need no clearing as the seen bits qualify them
`timescale 1ns / 1ps

module joint_velocity_pi_controller
    import jvpi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               sample_valid,
    output logic               sample_stall,
    input  sample_t            sample_word,

    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result_word,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [JOINT_INDEX_W:0] FREE_FLYER_LIMIT = (JOINT_INDEX_W+1)'(FREE_FLYER_COUNT);

    // configuration registers
    logic        [31:0] inverse_period_reg;
    logic signed [23:0] proportional_gain_reg;
    logic signed [23:0] integral_gain_reg;

    // stage valids and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic en1, en2, en3, en4, en5, en6, en7, en8;

    // per-joint stores
    logic signed [31:0]     pos_mem   [JOINT_COUNT];
    logic signed [47:0]     integ_mem [JOINT_COUNT];
    logic [JOINT_COUNT-1:0] seen_bits_reg;
    logic signed [31:0]     pos_rd_reg;
    logic signed [47:0]     integ_rd_reg;

    // stage 1: position read-modify-write
    logic [JOINT_INDEX_W-1:0] s1_idx_reg;
    logic signed [31:0]       s1_pos_reg, s1_ref_reg, s1_byp_reg;
    logic                     s1_hit_reg, s1_seen_reg, s1_nonff_reg;
    logic                     pos_hit;
    logic signed [31:0]       prev_eff;
    logic signed [32:0]       diff_next;

    // stage 2: velocity product
    logic [JOINT_INDEX_W-1:0] s2_idx_reg;
    logic signed [31:0]       s2_ref_reg;
    logic                     s2_seen_reg, s2_nonff_reg;
    logic signed [32:0]       s2_diff_reg;
    logic signed [65:0]       prod_next;

    // stage 3: velocity clamp and error
    logic [JOINT_INDEX_W-1:0] s3_idx_reg;
    logic signed [31:0]       s3_ref_reg;
    logic                     s3_seen_reg, s3_nonff_reg;
    logic signed [65:0]       s3_prod_reg;
    logic signed [49:0]       vel_wide;
    logic signed [31:0]       vel_next;
    logic                     vsat_next;
    logic signed [32:0]       err_next;

    // stage 4: integral read-modify-write
    logic [JOINT_INDEX_W-1:0] s4_idx_reg;
    logic signed [31:0]       s4_ref_reg, s4_vel_reg;
    logic                     s4_seen_reg, s4_nonff_reg, s4_sat_reg;
    logic signed [32:0]       s4_err_reg;
    logic signed [47:0]       s4_ibyp_reg;
    logic                     s4_ihit_reg;
    logic                     integ_hit;
    logic signed [47:0]       integ_old;
    logic signed [48:0]       integ_sum;
    logic signed [47:0]       integ_next;
    logic                     isat_next;

    // stage 5: gain products
    logic [JOINT_INDEX_W-1:0] s5_idx_reg;
    logic signed [31:0]       s5_ref_reg, s5_vel_reg;
    logic                     s5_nonff_reg, s5_sat_reg;
    logic signed [32:0]       s5_err_reg;
    logic signed [47:0]       s5_integ_reg;
    logic signed [56:0]       kp_err_next;
    logic signed [55:0]       ki_hi_next;
    logic signed [40:0]       ki_lo_next;

    // stage 6: sum of products
    logic [JOINT_INDEX_W-1:0] s6_idx_reg;
    logic signed [31:0]       s6_ref_reg, s6_vel_reg;
    logic                     s6_nonff_reg, s6_sat_reg;
    logic signed [56:0]       s6_kp_err_reg;
    logic signed [55:0]       s6_ki_hi_reg;
    logic signed [40:0]       s6_ki_lo_reg;
    logic signed [71:0]       total_next;
    logic signed [55:0]       acc_next;

    // stage 7: drive clamp and select
    logic [JOINT_INDEX_W-1:0] s7_idx_reg;
    logic signed [31:0]       s7_ref_reg, s7_vel_reg;
    logic                     s7_nonff_reg, s7_sat_reg;
    logic signed [55:0]       s7_acc_reg;
    logic signed [31:0]       dclamp;
    logic                     dsat;
    result_t                  result_next;

    // stage 8: output word
    result_t                  result_reg;

    // advance chain, bubbles collapse
    assign en8 = !v8_reg || !result_stall;
    assign en7 = !v7_reg || en8;
    assign en6 = !v6_reg || en7;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign sample_stall = !en1;
    assign result_valid = v8_reg;
    assign result_word  = result_reg;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_period_reg    <= INVERSE_PERIOD_RESET;
            proportional_gain_reg <= PROPORTIONAL_GAIN_RESET;
            integral_gain_reg     <= INTEGRAL_GAIN_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[PADDR_W-1:2])
                REG_INVERSE_PERIOD:    inverse_period_reg    <= pwdata;
                REG_PROPORTIONAL_GAIN: proportional_gain_reg <= pwdata[23:0];
                REG_INTEGRAL_GAIN:     integral_gain_reg     <= pwdata[23:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[PADDR_W-1:2])
            REG_INVERSE_PERIOD:    prdata = inverse_period_reg;
            REG_PROPORTIONAL_GAIN: prdata = 32'(proportional_gain_reg);
            REG_INTEGRAL_GAIN:     prdata = 32'(integral_gain_reg);
            default:               prdata = '0;
        endcase
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= sample_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg;
            if (en8) v8_reg <= v7_reg;
        end
    end

    // seen bits, set as a sample leaves stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_bits_reg <= '0;
        else if (v1_reg && en2)
            seen_bits_reg[s1_idx_reg] <= 1'b1;
    end

    // position memory: read on entry to stage 1, written on leaving it
    assign pos_hit = v1_reg && en2 && (sample_word.joint_index == s1_idx_reg);

    always_ff @(posedge clk)
    begin
        if (v1_reg && en2)
            pos_mem[s1_idx_reg] <= s1_pos_reg;
        if (en1)
            pos_rd_reg <= pos_mem[sample_word.joint_index];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_idx_reg   <= sample_word.joint_index;
            s1_pos_reg   <= sample_word.measured_position;
            s1_ref_reg   <= sample_word.reference_velocity;
            s1_hit_reg   <= pos_hit;
            s1_byp_reg   <= s1_pos_reg;
            s1_seen_reg  <= pos_hit || seen_bits_reg[sample_word.joint_index];
            s1_nonff_reg <= {1'b0, sample_word.joint_index} >= FREE_FLYER_LIMIT;
        end
    end

    // position difference, zero on a joint's first sample
    always_comb
    begin
        prev_eff = s1_hit_reg ? s1_byp_reg : pos_rd_reg;
        if (s1_seen_reg)
            diff_next = {s1_pos_reg[31], s1_pos_reg} - {prev_eff[31], prev_eff};
        else
            diff_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_idx_reg   <= s1_idx_reg;
            s2_ref_reg   <= s1_ref_reg;
            s2_seen_reg  <= s1_seen_reg;
            s2_nonff_reg <= s1_nonff_reg;
            s2_diff_reg  <= diff_next;
        end
    end

    // difference times reciprocal period
    assign prod_next = s2_diff_reg * $signed({1'b0, inverse_period_reg});

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_idx_reg   <= s2_idx_reg;
            s3_ref_reg   <= s2_ref_reg;
            s3_seen_reg  <= s2_seen_reg;
            s3_nonff_reg <= s2_nonff_reg;
            s3_prod_reg  <= prod_next;
        end
    end

    // floor shift, clamp velocity, velocity error
    always_comb
    begin
        vel_wide = s3_prod_reg[65:16];
        if (vel_wide[49:31] == {19{vel_wide[31]}})
        begin
            vel_next  = vel_wide[31:0];
            vsat_next = 1'b0;
        end
        else
        begin
            vel_next  = vel_wide[49] ? INT32_MIN : INT32_MAX;
            vsat_next = 1'b1;
        end
        err_next = {s3_ref_reg[31], s3_ref_reg} - {vel_next[31], vel_next};
    end

    // integral memory: read on entry to stage 4, written on leaving it
    assign integ_hit = v4_reg && en5 && s4_nonff_reg && (s3_idx_reg == s4_idx_reg);

    always_ff @(posedge clk)
    begin
        if (v4_reg && en5 && s4_nonff_reg)
            integ_mem[s4_idx_reg] <= integ_next;
        if (en4)
            integ_rd_reg <= integ_mem[s3_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_idx_reg   <= s3_idx_reg;
            s4_ref_reg   <= s3_ref_reg;
            s4_seen_reg  <= s3_seen_reg;
            s4_nonff_reg <= s3_nonff_reg;
            s4_vel_reg   <= vel_next;
            s4_err_reg   <= err_next;
            s4_sat_reg   <= vsat_next;
            s4_ihit_reg  <= integ_hit;
            s4_ibyp_reg  <= integ_next;
        end
    end

    // integral update with 48 bit saturation
    always_comb
    begin
        if (!s4_seen_reg)
            integ_old = '0;
        else if (s4_ihit_reg)
            integ_old = s4_ibyp_reg;
        else
            integ_old = integ_rd_reg;
        integ_sum = 49'(integ_old) + 49'(s4_err_reg);
        if (integ_sum[48] == integ_sum[47])
        begin
            integ_next = integ_sum[47:0];
            isat_next  = 1'b0;
        end
        else
        begin
            integ_next = integ_sum[48] ? INT48_MIN : INT48_MAX;
            isat_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_idx_reg   <= s4_idx_reg;
            s5_ref_reg   <= s4_ref_reg;
            s5_nonff_reg <= s4_nonff_reg;
            s5_vel_reg   <= s4_vel_reg;
            s5_err_reg   <= s4_err_reg;
            s5_integ_reg <= integ_next;
            s5_sat_reg   <= s4_sat_reg || (s4_nonff_reg && isat_next);
        end
    end

    // gain products, integral split into high word and low fraction
    assign kp_err_next = proportional_gain_reg * s5_err_reg;
    assign ki_hi_next  = integral_gain_reg * $signed(s5_integ_reg[47:16]);
    assign ki_lo_next  = integral_gain_reg * $signed({1'b0, s5_integ_reg[15:0]});

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_idx_reg    <= s5_idx_reg;
            s6_ref_reg    <= s5_ref_reg;
            s6_nonff_reg  <= s5_nonff_reg;
            s6_vel_reg    <= s5_vel_reg;
            s6_sat_reg    <= s5_sat_reg;
            s6_kp_err_reg <= kp_err_next;
            s6_ki_hi_reg  <= ki_hi_next;
            s6_ki_lo_reg  <= ki_lo_next;
        end
    end

    // exact sum, then floor shift
    assign total_next = (72'(s6_ki_hi_reg) <<< 16) + 72'(s6_kp_err_reg) + 72'(s6_ki_lo_reg);
    assign acc_next   = total_next[71:16];

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            s7_idx_reg   <= s6_idx_reg;
            s7_ref_reg   <= s6_ref_reg;
            s7_nonff_reg <= s6_nonff_reg;
            s7_vel_reg   <= s6_vel_reg;
            s7_sat_reg   <= s6_sat_reg;
            s7_acc_reg   <= acc_next;
        end
    end

    // drive clamp, free-flyer joints pass the reference
    always_comb
    begin
        if (s7_acc_reg[55:31] == {25{s7_acc_reg[31]}})
        begin
            dclamp = s7_acc_reg[31:0];
            dsat   = 1'b0;
        end
        else
        begin
            dclamp = s7_acc_reg[55] ? INT32_MIN : INT32_MAX;
            dsat   = 1'b1;
        end
        result_next.joint_tag          = s7_idx_reg;
        result_next.estimated_velocity = s7_vel_reg;
        result_next.drive_command      = s7_nonff_reg ? dclamp : s7_ref_reg;
        result_next.saturated_flag     = s7_sat_reg || (s7_nonff_reg && dsat);
    end

    always_ff @(posedge clk)
    begin
        if (en8)
            result_reg <= result_next;
    end

`ifndef SYNTH
    // a stalled input means stage 1 holds a word
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> v1_reg)
        else $error("input stalled with stage 1 empty");

    // a word leaving stage 1 marks its joint as seen
    a_seen_after_leave: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && en2) |=> seen_bits_reg[$past(s1_idx_reg)])
        else $error("seen bit not set after position write");

    // first sample of a joint gives zero velocity, no saturation
    a_first_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !s3_seen_reg) |-> (vel_next == 32'sd0) && !vsat_next)
        else $error("non-zero velocity on first sample");
`endif

endmodule

/* tb/joint_velocity_pi_controller_tb.sv */
// self-checking testbench for the joint velocity pi controller: driver, monitor and predictor
`timescale 1ns / 1ps

module joint_velocity_pi_controller_tb;

    import jvpi_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_WAIT      = 19;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 32;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PRINT_LIMIT   = 200;
    localparam int RANDOM_BATCH  = 200;
    localparam int WINDUP_STEPS  = 64;

    // register index with nothing behind it
    localparam logic [REG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               sample_valid = 1'b0;
    logic               sample_stall;
    sample_t            sample_word = '0;

    logic               result_valid;
    logic               result_stall = 1'b0;
    result_t            result_word;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // register copies as the block should hold them
    logic        [31:0] cfg_inverse_period = INVERSE_PERIOD_RESET;
    logic signed [23:0] cfg_kp = PROPORTIONAL_GAIN_RESET;
    logic signed [23:0] cfg_ki = INTEGRAL_GAIN_RESET;

    // per-joint state as the block should hold it
    logic signed [31:0] prev_position [JOINT_COUNT];
    bit                 joint_known   [JOINT_COUNT];
    logic signed [47:0] joint_integral[JOINT_COUNT];

    // positions last generated per joint, for smooth trajectories
    logic signed [31:0] walk_position [JOINT_COUNT];

    sample_t     pending_samples[$];
    result_t     predicted_results[$];

    bit          sender_idles = 1'b0;
    bit          receiver_idles = 1'b0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;

    joint_velocity_pi_controller u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    initial
    begin
        for (int k = 0; k < JOINT_COUNT; k++)
        begin
            prev_position[k]  = '0;
            joint_known[k]    = 1'b0;
            joint_integral[k] = '0;
            walk_position[k]  = '0;
        end
    end

    // clamp to a signed range of the given width
    function automatic logic signed [127:0] saturate(input logic signed [127:0] x,
                                                    input int bits);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
        lo = -(128'sd1 <<< (bits - 1));
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    // finite-difference velocity and pi drive for one sample, updating the joint state
    function automatic result_t predict_joint_result(sample_t s);
        result_t             r;
        logic signed [127:0] pos;
        logic signed [127:0] want_vel;
        logic signed [127:0] rate;
        logic signed [127:0] kp;
        logic signed [127:0] ki;
        logic signed [127:0] diff;
        logic signed [127:0] vel_raw;
        logic signed [127:0] vel;
        logic signed [127:0] err;
        logic signed [127:0] integ_raw;
        logic signed [127:0] integ;
        logic signed [127:0] acc_raw;
        logic signed [127:0] acc;
        bit                  hit;
        int unsigned         j;
        j        = 32'(s.joint_index);
        pos      = 128'($signed(s.measured_position));
        want_vel = 128'($signed(s.reference_velocity));
        rate     = {96'd0, cfg_inverse_period};
        kp       = 128'(cfg_kp);
        ki       = 128'(cfg_ki);
        hit      = 1'b0;
        vel      = '0;
        r.drive_command = s.reference_velocity;

        // first sample of a joint leaves the velocity at zero
        if (joint_known[j])
        begin
            diff    = pos - prev_position[j];
            vel_raw = (diff * rate) >>> 16;
            vel     = saturate(vel_raw, 32);
            if (vel != vel_raw)
                hit = 1'b1;
        end
        joint_known[j]   = 1'b1;
        prev_position[j] = s.measured_position;

        // joints past the free-flyer range run the pi loop; free-flyer joints pass the reference through
        if (j >= FREE_FLYER_COUNT)
        begin
            err       = want_vel - vel;
            integ_raw = joint_integral[j] + err;
            integ     = saturate(integ_raw, 48);
            if (integ != integ_raw)
                hit = 1'b1;
            joint_integral[j] = integ[47:0];
            acc_raw = (kp * err + ki * integ) >>> 16;
            acc     = saturate(acc_raw, 32);
            if (acc != acc_raw)
                hit = 1'b1;
            r.drive_command = acc[31:0];
        end

        r.joint_tag          = s.joint_index;
        r.estimated_velocity = vel[31:0];
        r.saturated_flag     = hit;
        return r;
    endfunction

    task automatic report_fault(string detail);
        fault_count++;
        if (fault_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, detail);
    endtask

    // compare one result word with the oldest prediction
    task automatic check_result(result_t got);
        result_t want;
        if (predicted_results.size() == 0)
        begin
            report_fault($sformatf("result for joint %0d with none outstanding", got.joint_tag));
            return;
        end
        want = predicted_results.pop_front();
        if (got.joint_tag !== want.joint_tag)
            report_fault($sformatf("joint_tag got %0d expected %0d",
                                   got.joint_tag, want.joint_tag));
        if (got.estimated_velocity !== want.estimated_velocity)
            report_fault($sformatf("joint %0d estimated_velocity got %h expected %h",
                                   want.joint_tag, got.estimated_velocity,
                                   want.estimated_velocity));
        if (got.drive_command !== want.drive_command)
            report_fault($sformatf("joint %0d drive_command got %h expected %h",
                                   want.joint_tag, got.drive_command, want.drive_command));
        if (got.saturated_flag !== want.saturated_flag)
            report_fault($sformatf("joint %0d saturated_flag got %b expected %b",
                                   want.joint_tag, got.saturated_flag, want.saturated_flag));
    endtask

    // sample driver: one word per handshake, random gap between words when the sender idles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                predicted_results.push_back(predict_joint_result(sample_word));
            if (!sample_valid || !sample_stall)
            begin
                if (send_wait != 0)
                begin
                    send_wait--;
                    sample_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    sample_word  <= pending_samples.pop_front();
                    sample_valid <= 1'b1;
                    send_wait = sender_idles ? $urandom_range(0, MAX_WAIT) : 0;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_requests != hold_served)
        begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_requests;
        end
    end

    // result monitor and stall generator
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                check_result(result_word);
                recv_wait = receiver_idles ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (hold_left != 0)
                result_stall <= 1'b1;
            else if (recv_wait != 0)
            begin
                recv_wait--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // apb write: setup then access, register taken when pready is high
    task automatic write_register(logic [REG_INDEX_W-1:0] index, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_INVERSE_PERIOD:    cfg_inverse_period = value;
            REG_PROPORTIONAL_GAIN: cfg_kp = value[23:0];
            REG_INTEGRAL_GAIN:     cfg_ki = value[23:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [31:0] rate, logic [23:0] kp, logic [23:0] ki);
        write_register(REG_INVERSE_PERIOD, rate);
        write_register(REG_PROPORTIONAL_GAIN, {{8{kp[23]}}, kp});
        write_register(REG_INTEGRAL_GAIN, {{8{ki[23]}}, ki});
    endtask

    task automatic push_sample(logic [JOINT_INDEX_W-1:0] joint, logic [31:0] pos,
                               logic [31:0] want_vel);
        sample_t s;
        s.joint_index        = joint;
        s.measured_position  = pos;
        s.reference_velocity = want_vel;
        walk_position[joint] = pos;
        pending_samples.push_back(s);
    endtask

    // mostly smooth per-joint trajectories, with jumps and full-range noise
    task automatic queue_random_samples(int count);
        int unsigned joint;
        int unsigned last_joint;
        int unsigned dice;
        logic [31:0] pos;
        logic [31:0] want_vel;
        last_joint = FREE_FLYER_COUNT;
        for (int n = 0; n < count; n++)
        begin
            dice = $urandom_range(0, 99);
            if (dice < 25)
                joint = last_joint;
            else if (dice < 40)
                joint = $urandom_range(0, FREE_FLYER_COUNT - 1);
            else if (dice < 80)
                joint = $urandom_range(FREE_FLYER_COUNT, FREE_FLYER_COUNT + 7);
            else
                joint = $urandom_range(0, JOINT_COUNT - 1);
            dice = $urandom_range(0, 99);
            if (dice < 70)
                pos = walk_position[joint] + (int'($urandom_range(0, 8191)) - 4096);
            else if (dice < 80)
                pos = walk_position[joint] + (int'($urandom_range(0, 1 << 24)) - (1 << 23));
            else
                pos = $urandom;
            if ($urandom_range(0, 99) < 60)
                want_vel = int'($urandom_range(0, 1 << 20)) - (1 << 19);
            else
                want_vel = $urandom;
            push_sample(JOINT_INDEX_W'(joint), pos, want_vel);
            last_joint = joint;
        end
    endtask

    // block idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        @(negedge clk);
        while (pending_samples.size() != 0 || sample_valid || predicted_results.size() != 0)
            @(negedge clk);
    endtask

    // test sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at reset settings
        push_sample(0, INT32_MAX, INT32_MAX);
        push_sample(0, INT32_MIN, INT32_MIN);
        push_sample(0, INT32_MAX, 0);
        push_sample(5, 100, -5);
        push_sample(5, 101, 7);
        push_sample(6, 0, INT32_MAX);
        push_sample(6, 0, INT32_MAX);
        push_sample(6, 65536, 0);
        push_sample(6, 65536, 0);
        push_sample(63, INT32_MIN, INT32_MIN);
        push_sample(63, INT32_MAX, INT32_MIN);
        push_sample(63, INT32_MIN, INT32_MAX);
        push_sample(63, -1, 0);
        push_sample(63, 0, 1);
        push_sample(7, 0, 0);
        push_sample(7, 1, 0);
        push_sample(7, 3, 0);
        push_sample(7, -3, 0);
        push_sample(7, -3, 0);
        push_sample(7, 32'h0000_7FFF, 0);
        push_sample(32, 32'h5555_5555, 32'hAAAA_AAAA);
        push_sample(31, 32'hAAAA_AAAA, 32'h5555_5555);
        wait_drained();

        // extreme settings, both sides idling
        apply_settings(32'hFFFF_FFFF, 24'h7F_FFFF, 24'h80_0000);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        queue_random_samples(RANDOM_BATCH);
        wait_drained();

        // opposite extremes, plus a write to the unmapped slot
        apply_settings(32'h0000_0000, 24'h80_0000, 24'h7F_FFFF);
        write_register(REG_UNMAPPED, $urandom);
        sender_idles   = 1'b1;
        receiver_idles = 1'b0;
        queue_random_samples(RANDOM_BATCH);
        wait_drained();

        // back-to-back words against a long receiver hold-off
        apply_settings(INVERSE_PERIOD_RESET, PROPORTIONAL_GAIN_RESET, 24'd655);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        queue_random_samples(RANDOM_BATCH);
        hold_requests++;
        wait_drained();

        // random settings with mixed idling
        for (int phase = 0; phase < 3; phase++)
        begin
            apply_settings($urandom, 24'($urandom), 24'($urandom));
            sender_idles   = (phase != 1);
            receiver_idles = (phase != 2);
            queue_random_samples(RANDOM_BATCH);
            wait_drained();
        end

        // sustained opposite errors on two joints, velocity and drive pinned at the limits
        apply_settings(32'hFFFF_FFFF, 24'd65536, 24'd65536);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        for (int i = 0; i < WINDUP_STEPS; i++)
        begin
            push_sample(7, 32'(longint'(INT32_MAX) - longint'(i) * 65536), INT32_MAX);
            push_sample(8, 32'(longint'(INT32_MIN) + longint'(i) * 65536), INT32_MIN);
        end
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
